>>> rtl/core/tcr_pkg.sv
// Shared types, constants and word-table functions for the token class recognizer.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

  // Default configuration of the word table
  localparam int TABLE_ENTRIES_DEF = 61;
  localparam int MAX_ENTRY_LEN_DEF = 9;
  localparam int TABLE_SLOTS       = 64;
  localparam int WORD_BYTES        = 16;

  // Entry index boundaries of the word groups
  localparam int KW_END    = 44;
  localparam int FN_END    = 54;
  localparam int OP_END    = 59;
  localparam int INC_ENTRY = 59;
  localparam int DEC_ENTRY = 60;

  // Character codes with a role of their own
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;

  // Result classes
  typedef enum logic [3:0] {
    CLS_KEYWORD  = 4'd0,
    CLS_FUNCTION = 4'd1,
    CLS_OPERATOR = 4'd2,
    CLS_IDENT    = 4'd3,
    CLS_INTEGER  = 4'd4,
    CLS_FLOAT    = 4'd5,
    CLS_INC      = 4'd6,
    CLS_DEC      = 4'd7,
    CLS_INVALID  = 4'd8
  } token_class_t;

  // Per-token summary handed from the front end to the back end
  typedef struct packed {
    logic kw_hit;
    logic fn_hit;
    logic op_hit;
    logic inc_hit;
    logic dec_hit;
    logic ident_ok;
    logic int_ok;
    logic float_ok;
  } summary_t;

  // Text of one table word, right-justified and zero padded
  function automatic logic [8*WORD_BYTES-1:0] word_text(input int e);
    logic [8*WORD_BYTES-1:0] t;
    case (e)
      0:  t = "asm";
      1:  t = "auto";
      2:  t = "break";
      3:  t = "case";
      4:  t = "char";
      5:  t = "class";
      6:  t = "const";
      7:  t = "continue";
      8:  t = "default";
      9:  t = "delete";
      10: t = "do";
      11: t = "double";
      12: t = "else";
      13: t = "enum";
      14: t = "extern";
      15: t = "float";
      16: t = "for";
      17: t = "friend";
      18: t = "goto";
      19: t = "if";
      20: t = "inline";
      21: t = "int";
      22: t = "long";
      23: t = "new";
      24: t = "operator";
      25: t = "private";
      26: t = "protected";
      27: t = "public";
      28: t = "register";
      29: t = "return";
      30: t = "short";
      31: t = "signed";
      32: t = "sizeof";
      33: t = "static";
      34: t = "struct";
      35: t = "switch";
      36: t = "template";
      37: t = "this";
      38: t = "typedef";
      39: t = "union";
      40: t = "unsigned";
      41: t = "virtual";
      42: t = "void";
      43: t = "while";
      44: t = "main";
      45: t = "clrscr";
      46: t = "printf";
      47: t = "scanf";
      48: t = "gets";
      49: t = "puts";
      50: t = "fopen";
      51: t = "fprintf";
      52: t = "fscanf";
      53: t = "getch";
      54: t = "+";
      55: t = "-";
      56: t = "*";
      57: t = "/";
      58: t = "%";
      59: t = "++";
      60: t = "--";
      default: t = '0;
    endcase
    return t;
  endfunction

  // Raw string length of one table word
  function automatic int word_raw_len(input int e);
    logic [8*WORD_BYTES-1:0] t;
    int n;
    t = word_text(e);
    n = 0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (t[8*i +: 8] != CH_NUL) n = i + 1;
    end
    return n;
  endfunction

  // Effective length of one table word, clipped to the entry length limit
  function automatic logic [3:0] word_len(input int e, input int max_len);
    int n;
    n = word_raw_len(e);
    if (n > max_len) n = max_len;
    if (n > 15) n = 15;
    return 4'(n);
  endfunction

  // Character at position p of one table word, zero beyond its end
  function automatic logic [7:0] word_char(input int e, input logic [3:0] p);
    logic [8*WORD_BYTES-1:0] t;
    int len;
    int idx;
    t   = word_text(e);
    len = word_raw_len(e);
    idx = len - 1 - int'(p);
    if (int'(p) < len) return t[8*idx +: 8];
    return CH_NUL;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tcr_front.sv
// Front end: accepts characters, tracks table candidates and token shape flags.
`timescale 1ns / 1ps
`default_nettype none

module tcr_front #(
  parameter int TABLE_ENTRIES = tcr_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_ENTRY_LEN = tcr_pkg::MAX_ENTRY_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_ch,
  input  logic              in_last_char,
  input  logic              q_full_i,
  output logic              push_o,
  output tcr_pkg::summary_t summary_o
);
  import tcr_pkg::*;

  logic [3:0]               pos_r, pos_nxt;
  logic [TABLE_ENTRIES-1:0] mask_r, mask_nxt;
  logic                     ident_r, ident_nxt;
  logic                     digits_r, digits_nxt;
  logic                     ddo_r, ddo_nxt;
  logic [1:0]               dots_r, dots_nxt;

  logic [TABLE_ENTRIES-1:0] keep;
  logic [TABLE_ENTRIES-1:0] exact;
  logic                     accept;
  logic                     is_letter;
  logic                     is_digit;
  logic                     is_ident_char;
  summary_t                 sum;

  assign in_ready = !q_full_i;
  assign accept   = in_valid && in_ready;

  // Classify the incoming character
  always_comb begin
    is_letter     = in_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_digit      = in_ch inside {[8'h30:8'h39]};
    is_ident_char = is_letter || (in_ch == CH_DOLLAR) || (in_ch == CH_UNDERSCORE);
  end

  // Narrow the candidate mask and find entries that end at this character
  always_comb begin
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      keep[e]  = mask_r[e] && (pos_r < word_len(e, MAX_ENTRY_LEN)) &&
                 (in_ch != CH_NUL) && (in_ch == word_char(e, pos_r));
      exact[e] = keep[e] &&
                 ({1'b0, word_len(e, MAX_ENTRY_LEN)} == ({1'b0, pos_r} + 5'd1));
    end
  end

  // Update the shape flags
  always_comb begin
    ident_nxt  = ident_r && (is_ident_char || ((pos_r != 4'd0) && is_digit));
    digits_nxt = digits_r && is_digit;
    ddo_nxt    = ddo_r && (is_digit || (in_ch == CH_DOT));
    dots_nxt   = dots_r;
    if ((in_ch == CH_DOT) && (dots_r != 2'd2)) dots_nxt = dots_r + 2'd1;
    pos_nxt    = (pos_r == 4'd15) ? pos_r : pos_r + 4'd1;
    mask_nxt   = keep;
  end

  // Reduce exact matches to word groups and build the token summary
  always_comb begin
    sum = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (exact[e]) begin
        if (e < KW_END)          sum.kw_hit  = 1'b1;
        else if (e < FN_END)     sum.fn_hit  = 1'b1;
        else if (e < OP_END)     sum.op_hit  = 1'b1;
        else if (e == INC_ENTRY) sum.inc_hit = 1'b1;
        else if (e == DEC_ENTRY) sum.dec_hit = 1'b1;
      end
    end
    sum.ident_ok = ident_nxt;
    sum.int_ok   = digits_nxt;
    sum.float_ok = ddo_nxt && (dots_nxt == 2'd1);
  end

  assign push_o    = accept && in_last_char;
  assign summary_o = sum;

  // Advance token state; drop it back to the start after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_char)) begin
      pos_r    <= '0;
      mask_r   <= '1;
      ident_r  <= 1'b1;
      digits_r <= 1'b1;
      ddo_r    <= 1'b1;
      dots_r   <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      mask_r   <= mask_nxt;
      ident_r  <= ident_nxt;
      digits_r <= digits_nxt;
      ddo_r    <= ddo_nxt;
      dots_r   <= dots_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tcr_queue.sv
// Two-entry queue of token summaries between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tcr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  tcr_pkg::summary_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tcr_pkg::summary_t data_o
);
  import tcr_pkg::*;

  logic     head_v_r, head_v_nxt;
  logic     tail_v_r, tail_v_nxt;
  summary_t head_r, head_nxt;
  summary_t tail_r, tail_nxt;

  // Shift on pop, then fill the first free slot on push
  always_comb begin
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    if (pop_i) begin
      head_v_nxt = tail_v_r;
      head_nxt   = tail_r;
      tail_v_nxt = 1'b0;
    end
    if (push_i) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_nxt   = data_i;
      end else begin
        tail_v_nxt = 1'b1;
        tail_nxt   = data_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full_o  = tail_v_r;
  assign valid_o = head_v_r;
  assign data_o  = head_r;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !tail_v_r)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> head_v_r)
    else $error("queue pop while empty");

  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    tail_v_r |-> head_v_r)
    else $error("queue tail valid without head");

  a_push_fills_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i && head_v_r) |=> tail_v_r)
    else $error("queue push onto busy head lost");

endmodule

`default_nettype wire

>>> rtl/core/tcr_back.sv
// Back end: resolves class priority and holds the result in an output register.
`timescale 1ns / 1ps
`default_nettype none

module tcr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid_i,
  input  tcr_pkg::summary_t q_data_i,
  output logic              pop_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_token_class
);
  import tcr_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  token_class_t cls_r, cls_nxt;
  token_class_t cls;

  // Pick the class by priority
  always_comb begin
    if (q_data_i.kw_hit)        cls = CLS_KEYWORD;
    else if (q_data_i.fn_hit)   cls = CLS_FUNCTION;
    else if (q_data_i.op_hit)   cls = CLS_OPERATOR;
    else if (q_data_i.ident_ok) cls = CLS_IDENT;
    else if (q_data_i.int_ok)   cls = CLS_INTEGER;
    else if (q_data_i.float_ok) cls = CLS_FLOAT;
    else if (q_data_i.inc_hit)  cls = CLS_INC;
    else if (q_data_i.dec_hit)  cls = CLS_DEC;
    else                        cls = CLS_INVALID;
  end

  // Load the output register whenever it is empty or being taken
  assign pop_o = q_valid_i && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    cls_nxt       = cls_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (pop_o) begin
      out_valid_nxt = 1'b1;
      cls_nxt       = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_token_class = cls_r;

endmodule

`default_nettype wire

>>> rtl/core/token_class_recognizer.sv
// Top level of the token class recognizer.
// Feed one token character per transaction, flagging the last one; a new character is
// taken every cycle while the queue has room. On the last character the block emits
// one class (keyword, library function, operator, identifier, integer, float, increment,
// decrement or invalid) via the queue and output register once the output is free. The
// rate is set by the front end, which narrows all table candidates in parallel for each
// character; the two-entry queue and output register let the result side stall without
// holding up input until the queue fills; table size and entry length limit are parameters.
`timescale 1ns / 1ps
`default_nettype none

module token_class_recognizer #(
  parameter int TABLE_ENTRIES = tcr_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_ENTRY_LEN = tcr_pkg::MAX_ENTRY_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_token_class
);
  import tcr_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  summary_t push_data;
  summary_t q_data;

  tcr_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_ENTRY_LEN(MAX_ENTRY_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ch       (in_ch),
    .in_last_char(in_last_char),
    .q_full_i    (q_full),
    .push_o      (push),
    .summary_o   (push_data)
  );

  tcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .data_i (push_data),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  tcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_class(out_token_class)
  );

endmodule

`default_nettype wire
